// File: rtl/html_tag_strip_text_filter_macros.svh
// ---------------------------------------------------------------------------
// HTML tag strip text filter: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef HTML_TAG_STRIP_TEXT_FILTER_MACROS_SVH
`define HTML_TAG_STRIP_TEXT_FILTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HTSF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HTSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/htsf_pkg.sv
// ---------------------------------------------------------------------------
// HTML tag strip text filter: shared package
// Character codes, sizes and the queue entry passed from front to back.
// ---------------------------------------------------------------------------
`default_nettype none

package htsf_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [11:0] WRAP_RESET = 12'd512;
  localparam logic [11:0] COUNT_MAX  = 12'd4095;
  localparam logic [3:0]  FILL_MAX   = 4'd15;

  // Entity window holds five stored bytes; the incoming byte is the sixth.
  localparam int ENT_STORE = 5;
  localparam int SPC_DEPTH = 5;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified input word: up to four text bytes, or an end-of-text mark.
  typedef struct packed {
    logic            fin;
    logic [2:0]      cnt;
    logic [3:0][7:0] bytes;
  } htsf_entry_t;

endpackage

`default_nettype wire

// File: rtl/html_tag_strip_text_filter.sv
// ---------------------------------------------------------------------------
// HTML tag strip text filter: top level
// Input channel: one word per HTML byte (in_byte_i, in_last_i) on in_valid_i /
// in_ready_o. Output channel: cleaned text words (out_byte_o, out_valid_o,
// out_last_o) on res_valid_o / res_ready_i. The cfg channel writes wrap_limit
// (12 bits, 512 after reset) and is always ready; write it between texts only.
// The front parses tags and takes one input word per cycle while the four-entry
// queue has room. The back runs one window step per cycle while the output
// register is free: plain text keeps one word per cycle, a break tag takes a
// step for each of its four bytes, and the end of text takes a step per pending
// window byte plus setup and the closing word. The entity and whitespace
// windows hold text back ahead of the output register, so a byte leaves
// roughly ten text bytes later. Every text ends with exactly one word marked
// out_last_o, an empty one (out_valid_o low) if nothing was left to send.
// Reset returns the parser, windows, queue and output register to empty and
// wrap_limit to 512. When the receiver stalls, the output register holds its
// word, the back stops, the queue fills and then in_ready_o drops.
// ---------------------------------------------------------------------------
`default_nettype none
`include "html_tag_strip_text_filter_macros.svh"

module html_tag_strip_text_filter import htsf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        in_last_i,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [11:0] cfg_data_i,
  output      logic        res_valid_o,
  input  wire logic        res_ready_i,
  output      logic [7:0]  out_byte_o,
  output      logic        out_valid_o,
  output      logic        out_last_o
);

  // Classified words travel from the parser to the windows through the queue.
  logic        q_push_valid, q_push_ready;
  htsf_entry_t q_push_data;
  logic        q_pop_valid, q_pop_ready;
  htsf_entry_t q_pop_data;

  // Conditions watched by the checks below.
  logic        text_head;
  logic        fin_retire;
  logic        empty_word;

  htsf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .push_valid_o (q_push_valid),
    .push_ready_i (q_push_ready),
    .push_data_o  (q_push_data)
  );

  htsf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  (q_push_data),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  htsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_valid),
    .pop_ready_o (q_pop_ready),
    .pop_data_i  (q_pop_data),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .out_byte_o  (out_byte_o),
    .out_valid_o (out_valid_o),
    .out_last_o  (out_last_o)
  );

  assign text_head  = q_pop_valid && !q_pop_data.fin;
  assign fin_retire = q_pop_valid && q_pop_ready && q_pop_data.fin;
  assign empty_word = res_valid_o && !out_valid_o;

  // The parser never queues a text entry without bytes.
  `HTSF_ASSERT_SAME(a_no_empty_entry, text_head, q_pop_data.cnt != 3'd0, "empty text entry")

  // Retiring an end-of-text entry always presents the closing word next cycle.
  `HTSF_ASSERT_NEXT(a_fin_closes, fin_retire, res_valid_o && out_last_o, "no closing word")

  // An empty word is only ever the closing word of a text.
  `HTSF_ASSERT_SAME(a_empty_last, empty_word, out_last_o && out_byte_o == 8'd0, "stray empty word")

endmodule

`default_nettype wire

// File: rtl/htsf_front.sv
// ---------------------------------------------------------------------------
// HTML tag strip text filter: front end
// Parses tags, counts line length and turns text bytes, break tags and the end of text into queue entries.
// ---------------------------------------------------------------------------
`default_nettype none

module htsf_front import htsf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        in_last_i,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [11:0] cfg_data_i,
  output      logic        push_valid_o,
  input  wire logic        push_ready_i,
  output      htsf_entry_t push_data_o
);

  localparam logic [1:0] MODE_TEXT   = 2'd0;
  localparam logic [1:0] MODE_FIRST  = 2'd1;
  localparam logic [1:0] MODE_SECOND = 2'd2;
  localparam logic [1:0] MODE_SKIP   = 2'd3;

  logic [1:0]  mode_q, mode_d;
  logic [7:0]  tfb_q, tfb_d;
  logic [11:0] lc_q, lc_d;
  logic        prev_q, prev_d;
  logic [11:0] wrap_q;
  logic        accept;
  logic        wrap;
  logic        enq;
  htsf_entry_t ent;

  function automatic logic break_tag(input logic [7:0] a_in, input logic [7:0] b_in);
    logic [7:0] a;
    logic [7:0] b;
    a = a_in | CASE_BIT;
    b = b_in | CASE_BIT;
    return (a == CH_P && b == CH_GT) || (a == CH_B && b == CH_R) ||
           (a == CH_H && b >= CH_ONE && b <= CH_SEVEN) ||
           (a == CH_SLASH && (b == CH_H || b == CH_T)) || (a == CH_T && b == CH_I);
  endfunction

  assign in_ready_o   = push_ready_i;
  assign accept       = in_valid_i && push_ready_i;
  assign cfg_ready_o  = 1'b1;
  assign push_valid_o = in_valid_i && enq;
  assign push_data_o  = ent;

  always_comb begin
    mode_d    = mode_q;
    tfb_d     = tfb_q;
    lc_d      = lc_q;
    prev_d    = prev_q;
    wrap      = 1'b0;
    ent.fin   = 1'b0;
    ent.cnt   = 3'd0;
    ent.bytes = '0;
    if (in_last_i || in_byte_i == CH_NUL) begin
      ent.fin = 1'b1;
      mode_d  = MODE_TEXT;
      tfb_d   = 8'd0;
      lc_d    = 12'd0;
      prev_d  = 1'b0;
    end else begin
      case (mode_q)
        MODE_TEXT: begin
          if (prev_q) begin
            if (in_byte_i == CH_CR) begin
              lc_d = 12'd0;
            end
            if (lc_d < COUNT_MAX) begin
              lc_d = lc_d + 12'd1;
            end
            if (lc_d > wrap_q && in_byte_i == CH_SP) begin
              lc_d = 12'd0;
              wrap = 1'b1;
            end
          end
          if (in_byte_i == CH_LT) begin
            mode_d = MODE_FIRST;
            prev_d = 1'b0;
          end else begin
            prev_d = 1'b1;
            if (wrap) begin
              ent.bytes[0] = CH_CR;
              ent.bytes[1] = CH_LF;
              ent.bytes[2] = in_byte_i;
              ent.cnt      = 3'd3;
            end else begin
              ent.bytes[0] = in_byte_i;
              ent.cnt      = 3'd1;
            end
          end
        end
        MODE_FIRST: begin
          if (in_byte_i == CH_GT) begin
            mode_d = MODE_TEXT;
          end else begin
            tfb_d  = in_byte_i;
            mode_d = MODE_SECOND;
          end
        end
        MODE_SECOND: begin
          if (break_tag(tfb_q, in_byte_i)) begin
            ent.bytes[0] = CH_CR;
            ent.bytes[1] = CH_LF;
            ent.bytes[2] = CH_SP;
            ent.bytes[3] = CH_SP;
            ent.cnt      = 3'd4;
            lc_d         = 12'd0;
          end
          mode_d = (in_byte_i == CH_GT) ? MODE_TEXT : MODE_SKIP;
        end
        default: begin
          if (in_byte_i == CH_GT) begin
            mode_d = MODE_TEXT;
          end
        end
      endcase
    end
    enq = ent.fin || (ent.cnt != 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TEXT;
      tfb_q  <= 8'd0;
      lc_q   <= 12'd0;
      prev_q <= 1'b0;
      wrap_q <= WRAP_RESET;
    end else begin
      if (accept) begin
        mode_q <= mode_d;
        tfb_q  <= tfb_d;
        lc_q   <= lc_d;
        prev_q <= prev_d;
      end
      if (cfg_valid_i) begin
        wrap_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/htsf_queue.sv
// ---------------------------------------------------------------------------
// HTML tag strip text filter: entry queue
// Small register FIFO that decouples the parser from the output windows.
// ---------------------------------------------------------------------------
`default_nettype none

module htsf_queue import htsf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_valid_i,
  output      logic        push_ready_o,
  input  wire htsf_entry_t push_data_i,
  output      logic        pop_valid_o,
  input  wire logic        pop_ready_i,
  output      htsf_entry_t pop_data_o
);

  htsf_entry_t       store_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = store_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/htsf_back.sv
// ---------------------------------------------------------------------------
// HTML tag strip text filter: back end
// Entity and whitespace windows, end-of-text flush and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module htsf_back import htsf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        pop_valid_i,
  output      logic        pop_ready_o,
  input  wire htsf_entry_t pop_data_i,
  output      logic        res_valid_o,
  input  wire logic        res_ready_i,
  output      logic [7:0]  out_byte_o,
  output      logic        out_valid_o,
  output      logic        out_last_o
);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;

  logic [7:0] ew_q [ENT_STORE];
  logic [7:0] ew_d [ENT_STORE];
  logic [7:0] sw_q [SPC_DEPTH];
  logic [7:0] sw_d [SPC_DEPTH];
  logic [7:0] pf_sw [SPC_DEPTH];
  logic [3:0] fill_q, fill_d;
  logic [1:0] idx_q, idx_d;
  logic [1:0] st_q, st_d;
  logic [2:0] fcnt_q, fcnt_d;
  logic [2:0] scc_q, scc_d;
  logic       hold_v_q, hold_v_d;
  logic [7:0] hold_b_q, hold_b_d;
  logic       res_v_q, res_v_d;
  logic [7:0] ob_q, ob_d;
  logic       ov_q, ov_d;
  logic       ol_q, ol_d;

  logic       out_free;
  logic [7:0] cur_b;
  logic       nbsp;
  logic [3:0] fill_m5;
  logic [2:0] sc_push;
  logic [7:0] pf_b;
  logic [2:0] pf_sc;
  logic       pf_emit;
  logic       all_blank;

  function automatic logic blank(input logic [7:0] b);
    return b == CH_CR || b == CH_LF || b == CH_TAB || b == CH_SP;
  endfunction

  assign out_free    = !res_v_q || res_ready_i;
  assign cur_b       = pop_data_i.bytes[idx_q];
  assign nbsp        = ew_q[1] == CH_N && ew_q[2] == CH_B && ew_q[3] == CH_S &&
                       ew_q[4] == CH_P;
  assign fill_m5     = fill_q - 4'd5;
  assign sc_push     = (fill_q >= 4'd10) ? 3'd5 : fill_m5[2:0];
  assign res_valid_o = res_v_q;
  assign out_byte_o  = ob_q;
  assign out_valid_o = ov_q;
  assign out_last_o  = ol_q;

  // Final whitespace window: shared by text pushes and the closing flush.
  always_comb begin
    if (st_q == ST_FLUSH) begin
      pf_b  = ew_q[0];
      pf_sc = scc_q;
    end else begin
      pf_b  = nbsp ? CH_SP : ew_q[0];
      pf_sc = sc_push;
    end
    all_blank = 1'b1;
    for (int i = 0; i < SPC_DEPTH; i++) begin
      if (!blank(sw_q[i])) begin
        all_blank = 1'b0;
      end
    end
    pf_sw   = sw_q;
    pf_emit = 1'b0;
    if (pf_sc >= 3'(SPC_DEPTH)) begin
      pf_emit = !all_blank;
      for (int i = 0; i < SPC_DEPTH - 1; i++) begin
        pf_sw[i] = sw_q[i+1];
      end
      pf_sw[SPC_DEPTH-1] = pf_b;
    end else begin
      pf_sw[pf_sc] = pf_b;
    end
  end

  always_comb begin
    ew_d        = ew_q;
    sw_d        = sw_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    st_d        = st_q;
    fcnt_d      = fcnt_q;
    scc_d       = scc_q;
    hold_v_d    = hold_v_q;
    hold_b_d    = hold_b_q;
    pop_ready_o = 1'b0;
    res_v_d     = res_ready_i ? 1'b0 : res_v_q;
    ob_d        = ob_q;
    ov_d        = ov_q;
    ol_d        = ol_q;
    case (st_q)
      ST_RUN: begin
        if (pop_valid_i && out_free) begin
          if (pop_data_i.fin) begin
            fcnt_d = (fill_q < 4'd5) ? fill_q[2:0] : 3'd5;
            scc_d  = (fill_q < 4'd5) ? 3'd0 : sc_push;
            st_d   = ST_FLUSH;
          end else begin
            if (fill_q < 4'd5) begin
              ew_d[fill_q[2:0]] = cur_b;
            end else begin
              for (int i = 0; i < ENT_STORE - 1; i++) begin
                ew_d[i] = nbsp ? CH_SP : ew_q[i+1];
              end
              ew_d[ENT_STORE-1] = nbsp ? CH_SP : cur_b;
              sw_d = pf_sw;
              if (pf_emit) begin
                res_v_d = 1'b1;
                ob_d    = sw_q[0];
                ov_d    = 1'b1;
                ol_d    = 1'b0;
              end
            end
            if (fill_q != FILL_MAX) begin
              fill_d = fill_q + 4'd1;
            end
            if (({1'b0, idx_q} + 3'd1) == pop_data_i.cnt) begin
              pop_ready_o = 1'b1;
              idx_d       = 2'd0;
            end else begin
              idx_d = idx_q + 2'd1;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          if (fcnt_q == 3'd0) begin
            // Closing word: the held byte, or an empty word, carries the last flag.
            res_v_d     = 1'b1;
            ob_d        = hold_v_q ? hold_b_q : 8'd0;
            ov_d        = hold_v_q;
            ol_d        = 1'b1;
            hold_v_d    = 1'b0;
            fill_d      = 4'd0;
            pop_ready_o = 1'b1;
            st_d        = ST_RUN;
          end else begin
            sw_d = pf_sw;
            for (int i = 0; i < ENT_STORE - 1; i++) begin
              ew_d[i] = ew_q[i+1];
            end
            fcnt_d = fcnt_q - 3'd1;
            scc_d  = (scc_q == 3'(SPC_DEPTH)) ? scc_q : scc_q + 3'd1;
            if (pf_emit) begin
              if (hold_v_q) begin
                res_v_d = 1'b1;
                ob_d    = hold_b_q;
                ov_d    = 1'b1;
                ol_d    = 1'b0;
              end
              hold_v_d = 1'b1;
              hold_b_d = sw_q[0];
            end
          end
        end
      end
      default: begin
        st_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ew_q     <= ew_d;
    sw_q     <= sw_d;
    fcnt_q   <= fcnt_d;
    scc_q    <= scc_d;
    hold_b_q <= hold_b_d;
    ob_q     <= ob_d;
    ov_q     <= ov_d;
    ol_q     <= ol_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= 4'd0;
      idx_q    <= 2'd0;
      st_q     <= ST_RUN;
      hold_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      idx_q    <= idx_d;
      st_q     <= st_d;
      hold_v_q <= hold_v_d;
      res_v_q  <= res_v_d;
    end
  end

endmodule

`default_nettype wire
